@@ design/bitmap_contiguous_page_allocator_core_macros.svh @@
// Assertion macros used by the allocator checker.
`ifndef BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCPA_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bcpa checker: same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define BCPA_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("bcpa checker: next-cycle implication failed");

`endif

@@ design/bcpa_pkg.sv @@
package bcpa_pkg;

  localparam int PAGE_TOTAL_DEF = 4096;
  localparam int MAX_RUN_DEF    = 63;
  localparam int WORD_BITS      = 64;
  // Page numbers stay below 8192; one extra bit holds a run end.
  localparam int PAGE_W         = 14;
  localparam int WIDX_W         = PAGE_W - 6;
  localparam int FIRST_W        = 12;
  localparam int END_W          = 13;
  localparam int COUNT_W        = 6;
  localparam int FREE_W         = 13;
  // Page numbers never reach 8192, so at most this many map words are touched.
  localparam int REACH_WORDS    = 128;

  localparam logic [END_W-1:0] END_RESET = 13'd4096;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_NO_RUN    = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic {
    REG_FIRST = 1'b0,
    REG_END   = 1'b1
  } reg_index_t;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [WIDX_W-1:0]    widx_t;

  typedef struct packed {
    mode_t              mode;
    logic [COUNT_W-1:0] page_count;
    logic [FIRST_W-1:0] start_page;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [FIRST_W-1:0] first_page;
    logic [FREE_W-1:0]  free_pages_left;
  } result_t;

  // Access to the page map from the sequencer.
  typedef struct packed {
    logic  wr_en;
    widx_t wr_word;
    word_t wr_data;
    widx_t rd_word;
  } map_req_t;

  function automatic logic [END_W-1:0] eff_end(input logic [END_W-1:0] last_end,
                                               input int map_pages);
    return (32'(last_end) > map_pages) ? END_W'(map_pages) : last_end;
  endfunction

  function automatic logic [FREE_W-1:0] region_size(input logic [FIRST_W-1:0] first,
                                                    input logic [END_W-1:0] last_end,
                                                    input int map_pages);
    logic [END_W-1:0] e;
    e = eff_end(last_end, map_pages);
    return (e > END_W'(first)) ? FREE_W'(e - END_W'(first)) : '0;
  endfunction

  // Bits of word w that fall inside the page range lo..hi, where w lies
  // between the words of lo and hi.
  function automatic word_t range_mask(input widx_t w, input page_t lo, input page_t hi);
    word_t m;
    m = '1;
    if (w == lo[PAGE_W-1:6]) m = m & (word_t'('1) << lo[5:0]);
    if (w == hi[PAGE_W-1:6]) m = m & (word_t'('1) >> (~hi[5:0]));
    return m;
  endfunction

endpackage

@@ design/bcpa_ram.sv @@
module bcpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ design/bcpa_map.sv @@
module bcpa_map #(
  parameter int WORDS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  bcpa_pkg::map_req_t req,
  output bcpa_pkg::word_t    rd_data
);
  import bcpa_pkg::*;

  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [WORDS-1:0] valid;
  logic             vld_q;
  word_t            ram_q;

  bcpa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(AW'(req.wr_word)),
    .wdata(req.wr_data),
    .raddr(AW'(req.rd_word)),
    .rdata(ram_q)
  );

  // A word never written since reset reads as all pages free.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[AW'(req.wr_word)] <= 1'b1;
    end
    vld_q <= valid[AW'(req.rd_word)];
  end

  assign rd_data = vld_q ? ram_q : '0;

endmodule

@@ design/bcpa_fit.sv @@
module bcpa_fit (
  input  bcpa_pkg::word_t              free_bits,
  input  bcpa_pkg::word_t              prev_free,
  input  logic [bcpa_pkg::COUNT_W-1:0] count,
  output logic                         hit,
  output logic [5:0]                   end_pos
);
  import bcpa_pkg::*;

  logic [2*WORD_BITS-1:0] g;
  logic [2*WORD_BITS-1:0] s;
  logic [2*WORD_BITS-1:0] r;

  assign g = {free_bits, prev_free};

  // s holds free windows of length 2^b ending at each bit; r grows by the
  // set bits of count, so at the end r marks each bit where a window of count free pages ends.
  always_comb begin
    s = g;
    r = '1;
    for (int b = 0; b < COUNT_W; b++) begin
      if (count[b]) r = (r << (1 << b)) & s;
      s = s & (s << (1 << b));
    end
    hit     = |r[2*WORD_BITS-1:WORD_BITS];
    end_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (r[WORD_BITS+i]) end_pos = 6'(i);
    end
  end

endmodule

@@ design/bitmap_contiguous_page_allocator_core.sv @@
// Contiguous page allocator over a one-bit-per-page map.
// A request is taken at a rising edge with start high and busy low. It either
// allocates page_count consecutive pages (first fit from the region start) or
// frees a run given by start_page and page_count. Every request gives exactly
// one result, shown on result for a single cycle with done high.
// A bad count, too few free pages, an empty region or a free outside the
// region is answered in the cycle after acceptance.
// An allocation reads the map one 64-page word per cycle, scanning words
// (up to 64 at the default size, from the region start word to the word
// holding the run's last page), then reads and writes back each word the
// run touches, one or two. A search that finds no run answers after the
// last region word. A free reads and writes back each word its run touches.
// busy drops in the cycle done is high, so the next request may start then.
// Region register writes take effect at once and reload the free count,
// unless a run is committed in the same cycle.
// Reset clears the map (per-word valid flags) and reloads the registers
// with their reset values. The receiver cannot stall.
module bitmap_contiguous_page_allocator_core #(
  parameter int PAGE_TOTAL = bcpa_pkg::PAGE_TOTAL_DEF,
  parameter int MAX_RUN    = bcpa_pkg::MAX_RUN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  bcpa_pkg::request_t         request,
  output logic                       done,
  output bcpa_pkg::result_t          result,
  input  logic                       cfg_write,
  input  bcpa_pkg::reg_index_t       cfg_index,
  input  logic [bcpa_pkg::END_W-1:0] cfg_data
);
  import bcpa_pkg::*;

  localparam int MapWords  = PAGE_TOTAL / WORD_BITS;
  localparam int MapPages  = MapWords * WORD_BITS;
  localparam int UsedWords = (MapWords < REACH_WORDS) ? MapWords : REACH_WORDS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_RD   = 4'b0100,
    S_WR   = 4'b1000
  } state_t;

  state_t              state;
  logic [FIRST_W-1:0]  region_first;
  logic [END_W-1:0]    region_end;
  logic [FREE_W-1:0]   free_total;
  mode_t               op_mode;
  logic [COUNT_W-1:0]  op_count;
  widx_t               scan_word;
  word_t               prev_free;
  page_t               run_lo;
  page_t               run_hi;
  widx_t               rmw_word;

  logic [FIRST_W-1:0]  first_next;
  logic [END_W-1:0]    end_next;
  logic [END_W-1:0]    end_eff;
  logic [FREE_W-1:0]   size_now;
  page_t               reg_hi;
  logic                region_ok;
  logic                accept;
  logic                bad_count;
  logic                too_few;
  page_t               free_end;
  logic                outside;
  map_req_t            map_req;
  word_t               map_data;
  word_t               free_bits;
  logic                hit;
  logic [5:0]          end_pos;
  page_t               run_last;
  page_t               run_start;
  logic                scan_last;
  word_t               wr_mask;
  logic [FREE_W:0]     free_sum;
  logic [FREE_W-1:0]   free_after;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign first_next = (cfg_write && cfg_index == REG_FIRST) ? cfg_data[FIRST_W-1:0]
                                                            : region_first;
  assign end_next   = (cfg_write && cfg_index == REG_END) ? cfg_data : region_end;

  assign end_eff   = eff_end(region_end, MapPages);
  assign size_now  = region_size(region_first, region_end, MapPages);
  assign region_ok = end_eff > END_W'(region_first);
  assign reg_hi    = page_t'(end_eff) - page_t'(1);

  assign bad_count = (request.page_count == '0) ||
                     (request.page_count > COUNT_W'(MAX_RUN));
  assign too_few   = FREE_W'(request.page_count) > free_total;
  assign free_end  = page_t'(request.start_page) + page_t'(request.page_count);
  assign outside   = (request.start_page < region_first) || (free_end > page_t'(end_eff));

  // Map access: the first region word is read while idle so that the scan
  // finds its data ready; during the scan the following word is prefetched.
  always_comb begin
    map_req.wr_en   = 1'b0;
    map_req.wr_word = rmw_word;
    map_req.wr_data = (op_mode == MODE_ALLOC) ? (map_data | wr_mask) : (map_data & ~wr_mask);
    unique case (state)
      S_IDLE:  map_req.rd_word = WIDX_W'(region_first >> 6);
      S_SCAN:  map_req.rd_word = WIDX_W'(scan_word + 1'b1);
      S_RD:    map_req.rd_word = rmw_word;
      S_WR: begin
        map_req.rd_word = rmw_word;
        map_req.wr_en   = 1'b1;
      end
      default: map_req.rd_word = rmw_word;
    endcase
  end

  bcpa_map #(
    .WORDS(UsedWords)
  ) u_map (
    .clk    (clk),
    .rst    (rst),
    .req    (map_req),
    .rd_data(map_data)
  );

  assign free_bits = ~map_data & range_mask(scan_word, page_t'(region_first), reg_hi);

  bcpa_fit u_fit (
    .free_bits(free_bits),
    .prev_free(prev_free),
    .count    (op_count),
    .hit      (hit),
    .end_pos  (end_pos)
  );

  assign run_last  = page_t'({scan_word, end_pos});
  assign run_start = run_last + page_t'(1) - page_t'(op_count);
  assign scan_last = (scan_word == reg_hi[PAGE_W-1:6]);
  assign wr_mask   = range_mask(rmw_word, run_lo, run_hi);

  assign free_sum   = {1'b0, free_total} + (FREE_W+1)'(op_count);
  assign free_after = (op_mode == MODE_ALLOC) ? (free_total - FREE_W'(op_count))
                    : ((free_sum > (FREE_W+1)'(size_now)) ? size_now : FREE_W'(free_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      region_first <= '0;
      region_end   <= END_RESET;
      free_total   <= region_size('0, END_RESET, MapPages);
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        region_first <= first_next;
        region_end   <= end_next;
        free_total   <= region_size(first_next, end_next, MapPages);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_mode  <= request.mode;
            op_count <= request.page_count;
            priority if (bad_count) begin
              done   <= 1'b1;
              result <= '{status: ST_BAD_COUNT, first_page: '0, free_pages_left: free_total};
            end else if (request.mode == MODE_ALLOC && (too_few || !region_ok)) begin
              done   <= 1'b1;
              result <= '{status: ST_NO_RUN, first_page: '0, free_pages_left: free_total};
            end else if (request.mode == MODE_ALLOC) begin
              scan_word <= WIDX_W'(region_first >> 6);
              prev_free <= '0;
              state     <= S_SCAN;
            end else if (outside) begin
              done   <= 1'b1;
              result <= '{status: ST_OUTSIDE, first_page: '0, free_pages_left: free_total};
            end else begin
              run_lo   <= page_t'(request.start_page);
              run_hi   <= free_end - page_t'(1);
              rmw_word <= WIDX_W'(request.start_page >> 6);
              state    <= S_RD;
            end
          end
        end
        S_SCAN: begin
          priority if (hit) begin
            run_lo   <= run_start;
            run_hi   <= run_last;
            rmw_word <= run_start[PAGE_W-1:6];
            state    <= S_RD;
          end else if (scan_last) begin
            done   <= 1'b1;
            result <= '{status: ST_NO_RUN, first_page: '0, free_pages_left: free_total};
            state  <= S_IDLE;
          end else begin
            scan_word <= WIDX_W'(scan_word + 1'b1);
            prev_free <= free_bits;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (rmw_word == run_hi[PAGE_W-1:6]) begin
            free_total <= free_after;
            done       <= 1'b1;
            result     <= '{status: ST_OK,
                            first_page: (op_mode == MODE_ALLOC) ? run_lo[FIRST_W-1:0] : '0,
                            free_pages_left: free_after};
            state      <= S_IDLE;
          end else begin
            rmw_word <= WIDX_W'(rmw_word + 1'b1);
            state    <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/bcpa_checker.sv @@
`include "bitmap_contiguous_page_allocator_core_macros.svh"

module bcpa_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input bcpa_pkg::result_t result
);
  import bcpa_pkg::*;

  // A result only follows an accepted transaction or work in progress.
  `BCPA_ASSERT_IMP(a_done_has_source, clk, rst, done, $past(busy || start))
  // The sequencer only leaves idle on an accepted transaction.
  `BCPA_ASSERT_IMP(a_busy_from_start, clk, rst, $rose(busy), $past(start))
  // Every accepted transaction is either answered at once or keeps the block busy.
  `BCPA_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, done || busy)
  // A failed request never reports an allocated page.
  `BCPA_ASSERT_IMP(a_fail_no_page, clk, rst, done && result.status != ST_OK,
                   result.first_page == '0)

endmodule

bind bitmap_contiguous_page_allocator_core bcpa_checker u_bcpa_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
